### hw/rtl/mcwc_pkg.sv
// Shared types and constants for the multichannel window convolution block.
// No dependencies.
`timescale 1ns / 1ps

package mcwc_pkg;

    localparam logic OP_COEF  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_KERNEL_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_KERNEL_WIDTH  = 2'd2;

    localparam logic [11:0] IMAGE_WIDTH_RST   = 12'd640;
    localparam logic [2:0]  KERNEL_HEIGHT_RST = 3'd3;
    localparam logic [2:0]  KERNEL_WIDTH_RST  = 3'd3;

    localparam logic [11:0] ROW_LIMIT = 12'd4095;
    localparam int          PIXEL_MAX = 255;

    localparam int QDEPTH = 4;
    localparam int QLW    = 3;

    typedef struct packed {
        logic [11:0] image_width;
        logic [2:0]  kernel_height;
        logic [2:0]  kernel_width;
    } cfg_t;

    typedef struct packed {
        logic        is_coef;
        logic [2:0]  coef_row;
        logic [2:0]  coef_col;
        logic [1:0]  coef_ch;
        logic [15:0] coef_value;
        logic [11:0] row;
        logic [10:0] col;
    } cmd_t;

endpackage

### hw/rtl/mcwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mcwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/mcwc_front.sv
// Front end: accepts words, tracks raster position, runs line buffers and window.
// Depends on mcwc_pkg and mcwc_ram.
`timescale 1ns / 1ps

module mcwc_front #(
    parameter int MAX_KERNEL_ROWS = 7,
    parameter int MAX_KERNEL_COLS = 7,
    parameter int CHANNELS        = 3,
    parameter int MAX_IMAGE_WIDTH = 2048
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  mcwc_pkg::cfg_t                          cfg,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    opcode,
    input  logic                                    frame_start,
    input  logic [7:0]                              sample_ch0,
    input  logic [7:0]                              sample_ch1,
    input  logic [7:0]                              sample_ch2,
    input  logic [2:0]                              coef_row,
    input  logic [2:0]                              coef_col,
    input  logic [1:0]                              coef_channel,
    input  logic [15:0]                             coef_value,
    input  logic [mcwc_pkg::QLW-1:0]                q_level,
    output logic                                    push,
    output mcwc_pkg::cmd_t                          push_cmd,
    output logic [MAX_KERNEL_ROWS*MAX_KERNEL_COLS*CHANNELS*8-1:0] push_win
);

    localparam int PW   = CHANNELS * 8;
    localparam int CW   = $clog2(MAX_IMAGE_WIDTH);
    localparam int EW   = CW + 1;
    localparam int LBN  = (MAX_KERNEL_ROWS > 1) ? MAX_KERNEL_ROWS - 1 : 1;
    localparam int LBW  = LBN * PW;
    localparam int WINW = MAX_KERNEL_ROWS * MAX_KERNEL_COLS * PW;

    logic              acc;
    logic              is_pixel;
    logic [CW-1:0]     cur_col;
    logic [11:0]       cur_row;
    logic [CW-1:0]     rd_addr;
    logic [EW-1:0]     eff_width;
    logic [EW-1:0]     col_p1;
    logic [12:0]       row_p1;
    logic              emit;
    logic [31:0]       samples;
    logic [PW-1:0]     px;
    logic              pend;

    logic [CW-1:0]     col_reg;
    logic [11:0]       row_reg;

    logic              s1_valid_reg;
    mcwc_pkg::cmd_t    s1_cmd_reg;
    logic [PW-1:0]     s1_px_reg;
    logic [CW-1:0]     s1_addr_reg;
    logic              s1_emit_reg;

    logic              wr_valid_reg;
    logic [CW-1:0]     wr_addr_reg;
    logic [LBW-1:0]    wr_data_reg;

    logic [LBW-1:0]    ram_rdata;
    logic [LBW-1:0]    lb_rd;
    logic [LBW-1:0]    new_line;
    logic              lb_we;
    logic [PW-1:0]     col_vec [MAX_KERNEL_ROWS];
    logic [WINW-1:0]   win_reg;
    logic [WINW-1:0]   win_next;

    assign pend     = s1_valid_reg && (s1_cmd_reg.is_coef || s1_emit_reg);
    assign in_ready = (int'(q_level) + int'(pend)) < mcwc_pkg::QDEPTH;
    assign acc      = in_valid && in_ready;
    assign is_pixel = (opcode == mcwc_pkg::OP_PIXEL);

    always_comb
    begin
        samples = {8'd0, sample_ch2, sample_ch1, sample_ch0};
        px = '0;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            px[ch*8 +: 8] = samples[ch*8 +: 8];
        end
    end

    always_comb
    begin
        cur_col = frame_start ? '0 : col_reg;
        cur_row = frame_start ? '0 : row_reg;
        if (int'(cur_col) >= MAX_IMAGE_WIDTH)
        begin
            rd_addr = CW'(MAX_IMAGE_WIDTH - 1);
        end
        else
        begin
            rd_addr = cur_col;
        end
        if (cfg.image_width == '0)
        begin
            eff_width = EW'(1);
        end
        else if (int'(cfg.image_width) > MAX_IMAGE_WIDTH)
        begin
            eff_width = EW'(MAX_IMAGE_WIDTH);
        end
        else
        begin
            eff_width = EW'(cfg.image_width);
        end
        col_p1 = EW'(cur_col) + EW'(1);
        row_p1 = 13'(cur_row) + 13'd1;
        emit   = (row_p1 >= 13'(cfg.kernel_height)) &&
                 (col_p1 >= EW'(cfg.kernel_width));
    end

    // position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (acc && is_pixel)
        begin
            if (col_p1 >= eff_width)
            begin
                col_reg <= '0;
                row_reg <= (cur_row < mcwc_pkg::ROW_LIMIT) ? cur_row + 12'd1 : cur_row;
            end
            else
            begin
                col_reg <= col_p1[CW-1:0];
                row_reg <= cur_row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= acc;
            wr_valid_reg <= lb_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_cmd_reg.is_coef    <= !is_pixel;
            s1_cmd_reg.coef_row   <= coef_row;
            s1_cmd_reg.coef_col   <= coef_col;
            s1_cmd_reg.coef_ch    <= coef_channel;
            s1_cmd_reg.coef_value <= coef_value;
            s1_cmd_reg.row        <= 12'(row_p1 - 13'(cfg.kernel_height));
            s1_cmd_reg.col        <= 11'(col_p1 - EW'(cfg.kernel_width));
            s1_px_reg             <= px;
            s1_addr_reg           <= rd_addr;
            s1_emit_reg           <= is_pixel && emit;
        end
        if (lb_we)
        begin
            wr_addr_reg <= s1_addr_reg;
            wr_data_reg <= new_line;
        end
    end

    mcwc_ram #(
        .WIDTH (LBW),
        .DEPTH (MAX_IMAGE_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (lb_we),
        .waddr (s1_addr_reg),
        .wdata (new_line),
        .re    (acc && is_pixel),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // same column written last cycle: forward the fresh line
    assign lb_rd    = (wr_valid_reg && (wr_addr_reg == s1_addr_reg)) ? wr_data_reg : ram_rdata;
    assign new_line = LBW'({lb_rd, s1_px_reg});
    assign lb_we    = s1_valid_reg && !s1_cmd_reg.is_coef;

    always_comb
    begin
        col_vec[0] = s1_px_reg;
        for (int d = 1; d < MAX_KERNEL_ROWS; d++)
        begin
            col_vec[d] = lb_rd[(d-1)*PW +: PW];
        end
        for (int d = 0; d < MAX_KERNEL_ROWS; d++)
        begin
            for (int wc = 0; wc < MAX_KERNEL_COLS; wc++)
            begin
                if (wc < MAX_KERNEL_COLS - 1)
                begin
                    win_next[(d*MAX_KERNEL_COLS+wc)*PW +: PW] =
                        win_reg[(d*MAX_KERNEL_COLS+wc+1)*PW +: PW];
                end
                else
                begin
                    win_next[(d*MAX_KERNEL_COLS+wc)*PW +: PW] = col_vec[d];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (lb_we)
        begin
            win_reg <= win_next;
        end
    end

    assign push     = pend;
    assign push_cmd = s1_cmd_reg;
    assign push_win = win_next;

endmodule

### hw/rtl/mcwc_queue.sv
// Short FIFO between front and back end; head is visible combinationally.
// Depends on mcwc_pkg for the level width.
`timescale 1ns / 1ps

module mcwc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [WIDTH-1:0]            push_data,
    input  logic                        pop,
    output logic                        head_valid,
    output logic [WIDTH-1:0]            head_data,
    output logic [mcwc_pkg::QLW-1:0]    level
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = mcwc_pkg::QLW;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wptr_reg;
    logic [AW-1:0]    rptr_reg;
    logic [LW-1:0]    level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            level_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (int'(wptr_reg) == DEPTH - 1) ? '0 : wptr_reg + AW'(1);
            end
            if (pop)
            begin
                rptr_reg <= (int'(rptr_reg) == DEPTH - 1) ? '0 : rptr_reg + AW'(1);
            end
            level_reg <= level_reg + LW'(push) - LW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= push_data;
        end
    end

    assign head_valid = (level_reg != '0);
    assign head_data  = mem[rptr_reg];
    assign level      = level_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (int'(level_reg) < DEPTH) || pop)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> level_reg != '0)
        else $error("queue underflow");

    a_level_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> level_reg == LW'($past(level_reg) + LW'($past(push)) - LW'($past(pop))))
        else $error("queue level mismatch");

endmodule

### hw/rtl/mcwc_back.sv
// Back end: coefficient store, multiply lanes, registered adder tree, clamp, output.
// Depends on mcwc_pkg.
`timescale 1ns / 1ps

module mcwc_back #(
    parameter int MAX_KERNEL_ROWS = 7,
    parameter int MAX_KERNEL_COLS = 7,
    parameter int CHANNELS        = 3,
    parameter int COEF_BITS       = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mcwc_pkg::cfg_t         cfg,
    input  logic                   q_valid,
    input  mcwc_pkg::cmd_t         q_cmd,
    input  logic [MAX_KERNEL_ROWS*MAX_KERNEL_COLS*CHANNELS*8-1:0] q_win,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [11:0]            out_row,
    output logic [10:0]            out_col,
    output logic [7:0]             result_ch0,
    output logic [7:0]             result_ch1,
    output logic [7:0]             result_ch2
);

    localparam int PW  = CHANNELS * 8;
    localparam int PRW = COEF_BITS + 9;
    localparam int SW  = PRW + $clog2(MAX_KERNEL_ROWS * MAX_KERNEL_COLS) + 1;
    localparam int RW  = (MAX_KERNEL_ROWS > 1) ? $clog2(MAX_KERNEL_ROWS) : 1;
    localparam int CLW = (MAX_KERNEL_COLS > 1) ? $clog2(MAX_KERNEL_COLS) : 1;
    localparam logic signed [SW-1:0] CLAMP_HI = SW'(mcwc_pkg::PIXEL_MAX * 256);

    logic ena;

    logic signed [COEF_BITS-1:0] coef_reg  [MAX_KERNEL_ROWS][MAX_KERNEL_COLS][CHANNELS];
    logic signed [COEF_BITS-1:0] lane_coef [MAX_KERNEL_ROWS][MAX_KERNEL_COLS][CHANNELS];
    logic [7:0]                  lane_px   [MAX_KERNEL_ROWS][MAX_KERNEL_COLS][CHANNELS];
    logic [31:0]                 coef_ext;

    logic                  b0_valid_reg;
    logic [11:0]           b0_row_reg;
    logic [10:0]           b0_col_reg;
    logic signed [PRW-1:0] prod_reg [MAX_KERNEL_ROWS][MAX_KERNEL_COLS][CHANNELS];

    logic                  b1_valid_reg;
    logic [11:0]           b1_row_reg;
    logic [10:0]           b1_col_reg;
    logic signed [SW-1:0]  rs_next [MAX_KERNEL_ROWS][CHANNELS];
    logic signed [SW-1:0]  rs_reg  [MAX_KERNEL_ROWS][CHANNELS];

    logic                  b2_valid_reg;
    logic [11:0]           b2_row_reg;
    logic [10:0]           b2_col_reg;
    logic signed [SW-1:0]  tot_next [CHANNELS];
    logic signed [SW-1:0]  tot_reg  [CHANNELS];

    logic [SW-1:0]         rnd    [CHANNELS];
    logic [7:0]            res    [4];
    logic                  out_valid_reg;
    logic [11:0]           out_row_reg;
    logic [10:0]           out_col_reg;
    logic [7:0]            res_reg [3];

    assign ena = !out_valid_reg || out_ready;
    assign pop = q_valid && ena;

    assign coef_ext = {{16{q_cmd.coef_value[15]}}, q_cmd.coef_value};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_KERNEL_ROWS; i++)
            begin
                for (int j = 0; j < MAX_KERNEL_COLS; j++)
                begin
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        coef_reg[i][j][c] <= '0;
                    end
                end
            end
        end
        else if (pop && q_cmd.is_coef)
        begin
            for (int i = 0; i < MAX_KERNEL_ROWS; i++)
            begin
                for (int j = 0; j < MAX_KERNEL_COLS; j++)
                begin
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        if (int'(q_cmd.coef_row) == i && int'(q_cmd.coef_col) == j &&
                            int'(q_cmd.coef_ch) == c)
                        begin
                            coef_reg[i][j][c] <= coef_ext[COEF_BITS-1:0];
                        end
                    end
                end
            end
        end
    end

    // window row d holds kernel row kh-1-d; column wc holds kernel column wc+kw-MAXC
    // lanes outside the kernel see zero pixels so stale window contents never matter
    always_comb
    begin
        int ii;
        int jj;
        for (int d = 0; d < MAX_KERNEL_ROWS; d++)
        begin
            for (int wc = 0; wc < MAX_KERNEL_COLS; wc++)
            begin
                ii = int'(cfg.kernel_height) - 1 - d;
                jj = wc + int'(cfg.kernel_width) - MAX_KERNEL_COLS;
                for (int c = 0; c < CHANNELS; c++)
                begin
                    if (ii >= 0 && jj >= 0 && ii < MAX_KERNEL_ROWS)
                    begin
                        lane_px[d][wc][c]   = q_win[(d*MAX_KERNEL_COLS+wc)*PW + c*8 +: 8];
                        lane_coef[d][wc][c] = coef_reg[RW'(ii)][CLW'(jj)][c];
                    end
                    else
                    begin
                        lane_px[d][wc][c]   = 8'd0;
                        lane_coef[d][wc][c] = '0;
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int d = 0; d < MAX_KERNEL_ROWS; d++)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                rs_next[d][c] = '0;
                for (int wc = 0; wc < MAX_KERNEL_COLS; wc++)
                begin
                    rs_next[d][c] = rs_next[d][c] + SW'(prod_reg[d][wc][c]);
                end
            end
        end
        for (int c = 0; c < CHANNELS; c++)
        begin
            tot_next[c] = '0;
            for (int d = 0; d < MAX_KERNEL_ROWS; d++)
            begin
                tot_next[c] = tot_next[c] + rs_reg[d][c];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            res[k] = 8'd0;
        end
        for (int c = 0; c < CHANNELS; c++)
        begin
            rnd[c] = tot_reg[c] + SW'(128);
            if (tot_reg[c] > CLAMP_HI)
            begin
                res[c] = 8'(mcwc_pkg::PIXEL_MAX);
            end
            else if (tot_reg[c] < 0)
            begin
                res[c] = 8'd0;
            end
            else
            begin
                res[c] = rnd[c][15:8];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg  <= 1'b0;
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (ena)
        begin
            b0_valid_reg  <= pop && !q_cmd.is_coef;
            b1_valid_reg  <= b0_valid_reg;
            b2_valid_reg  <= b1_valid_reg;
            out_valid_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ena)
        begin
            b0_row_reg <= q_cmd.row;
            b0_col_reg <= q_cmd.col;
            for (int d = 0; d < MAX_KERNEL_ROWS; d++)
            begin
                for (int wc = 0; wc < MAX_KERNEL_COLS; wc++)
                begin
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        prod_reg[d][wc][c] <= $signed({1'b0, lane_px[d][wc][c]}) *
                                              lane_coef[d][wc][c];
                    end
                end
            end
            b1_row_reg <= b0_row_reg;
            b1_col_reg <= b0_col_reg;
            rs_reg     <= rs_next;
            b2_row_reg <= b1_row_reg;
            b2_col_reg <= b1_col_reg;
            tot_reg    <= tot_next;
            if (b2_valid_reg)
            begin
                out_row_reg <= b2_row_reg;
                out_col_reg <= b2_col_reg;
                for (int k = 0; k < 3; k++)
                begin
                    res_reg[k] <= res[k];
                end
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign result_ch0 = res_reg[0];
    assign result_ch1 = res_reg[1];
    assign result_ch2 = res_reg[2];

endmodule

### hw/rtl/multichannel_window_convolution.sv
// Top level of the per-channel 2D window convolution: config registers, front, queue, back.
// Throughput: one word per cycle while the queue has room; a result passes through the line RAM
// read, window shift, queue, multiply stage, two adder stages and output register.
// Output stalls back up through the 4-entry queue to in_ready.
// Reset: config returns to width 640 and a 3x3 kernel, coefficients clear to zero,
// position counters clear; line buffer and window contents are undefined until written.
`timescale 1ns / 1ps

module multichannel_window_convolution #(
    parameter int MAX_KERNEL_ROWS = 7,
    parameter int MAX_KERNEL_COLS = 7,
    parameter int CHANNELS        = 3,
    parameter int MAX_IMAGE_WIDTH = 2048,
    parameter int COEF_BITS       = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic        frame_start,
    input  logic [7:0]  sample_ch0,
    input  logic [7:0]  sample_ch1,
    input  logic [7:0]  sample_ch2,
    input  logic [2:0]  coef_row,
    input  logic [2:0]  coef_col,
    input  logic [1:0]  coef_channel,
    input  logic [15:0] coef_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] out_row,
    output logic [10:0] out_col,
    output logic [7:0]  result_ch0,
    output logic [7:0]  result_ch1,
    output logic [7:0]  result_ch2
);

    localparam int WINW = MAX_KERNEL_ROWS * MAX_KERNEL_COLS * CHANNELS * 8;
    localparam int CMDW = $bits(mcwc_pkg::cmd_t);
    localparam int QW   = CMDW + WINW;

    mcwc_pkg::cfg_t             cfg_reg;
    logic                       push;
    mcwc_pkg::cmd_t             push_cmd;
    logic [WINW-1:0]            push_win;
    logic                       pop;
    logic                       q_valid;
    logic [QW-1:0]              q_data;
    logic [mcwc_pkg::QLW-1:0]   q_level;
    mcwc_pkg::cmd_t             q_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width   <= mcwc_pkg::IMAGE_WIDTH_RST;
            cfg_reg.kernel_height <= mcwc_pkg::KERNEL_HEIGHT_RST;
            cfg_reg.kernel_width  <= mcwc_pkg::KERNEL_WIDTH_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mcwc_pkg::CFG_IMAGE_WIDTH:
                begin
                    cfg_reg.image_width <= cfg_data;
                end
                mcwc_pkg::CFG_KERNEL_HEIGHT:
                begin
                    if (cfg_data[0] && int'(cfg_data[2:0]) <= MAX_KERNEL_ROWS)
                    begin
                        cfg_reg.kernel_height <= cfg_data[2:0];
                    end
                end
                mcwc_pkg::CFG_KERNEL_WIDTH:
                begin
                    if (cfg_data[0] && int'(cfg_data[2:0]) <= MAX_KERNEL_COLS)
                    begin
                        cfg_reg.kernel_width <= cfg_data[2:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    mcwc_front #(
        .MAX_KERNEL_ROWS (MAX_KERNEL_ROWS),
        .MAX_KERNEL_COLS (MAX_KERNEL_COLS),
        .CHANNELS        (CHANNELS),
        .MAX_IMAGE_WIDTH (MAX_IMAGE_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .frame_start  (frame_start),
        .sample_ch0   (sample_ch0),
        .sample_ch1   (sample_ch1),
        .sample_ch2   (sample_ch2),
        .coef_row     (coef_row),
        .coef_col     (coef_col),
        .coef_channel (coef_channel),
        .coef_value   (coef_value),
        .q_level      (q_level),
        .push         (push),
        .push_cmd     (push_cmd),
        .push_win     (push_win)
    );

    mcwc_queue #(
        .WIDTH (QW),
        .DEPTH (mcwc_pkg::QDEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({push_cmd, push_win}),
        .pop        (pop),
        .head_valid (q_valid),
        .head_data  (q_data),
        .level      (q_level)
    );

    assign q_cmd = q_data[QW-1:WINW];

    mcwc_back #(
        .MAX_KERNEL_ROWS (MAX_KERNEL_ROWS),
        .MAX_KERNEL_COLS (MAX_KERNEL_COLS),
        .CHANNELS        (CHANNELS),
        .COEF_BITS       (COEF_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_win      (q_data[WINW-1:0]),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_row    (out_row),
        .out_col    (out_col),
        .result_ch0 (result_ch0),
        .result_ch1 (result_ch1),
        .result_ch2 (result_ch2)
    );

endmodule

### tb/tb_top.sv
// Self-checking testbench for multichannel_window_convolution: random and directed words,
// a built-in convolution predictor and a scoreboard of expected filtered pixels.
// Depends on mcwc_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        logic        op;
        logic        fs;
        logic [7:0]  s0, s1, s2;
        logic [2:0]  cr, cc;
        logic [1:0]  cch;
        logic [15:0] cv;
    } word_t;

    typedef struct {
        logic [11:0] row;
        logic [10:0] col;
        logic [7:0]  r0, r1, r2;
    } pix_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = mcwc_pkg::CFG_IMAGE_WIDTH;
    logic [11:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        opcode = mcwc_pkg::OP_PIXEL;
    logic        frame_start = 1'b0;
    logic [7:0]  sample_ch0 = '0, sample_ch1 = '0, sample_ch2 = '0;
    logic [2:0]  coef_row = '0, coef_col = '0;
    logic [1:0]  coef_channel = '0;
    logic [15:0] coef_value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [11:0] out_row;
    logic [10:0] out_col;
    logic [7:0]  result_ch0, result_ch1, result_ch2;

    multichannel_window_convolution uut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    int           m_width = 640, m_kh = 3, m_kw = 3;
    int           m_col = 0, m_row = 0;
    int           coefs [7][7][3];
    bit [23:0]    lines [6][2048];
    bit [23:0]    win [7][7];

    word_t        pending [$];
    pix_out_t     expected_pix [$];
    int           errors = 0;
    int           idle_cycles = 0;
    logic         in_took = 1'b0;
    int           gap_left = 0, burst_left = 1;
    int           stall_mode = 0, stall_cnt = 0;
    int           rand_words = 0;

    function automatic logic [7:0] filter_ch(int ch);
        longint acc;
        int     px;
        acc = 0;
        for (int i = 0; i < m_kh; i++)
            for (int j = 0; j < m_kw; j++)
            begin
                px = (win[m_kh - 1 - i][7 - m_kw + j] >> (8 * ch)) & 8'hFF;
                acc += longint'(px) * longint'(coefs[i][j][ch]);
            end
        if (acc > 255 * 256)
            return 8'd255;
        if (acc < 0)
            return 8'd0;
        return 8'((acc + 128) >>> 8);
    endfunction

    task automatic convolve_word(input word_t w);
        bit [23:0] colv [7];
        pix_out_t  o;
        int        eff;
        if (w.op == mcwc_pkg::OP_COEF)
        begin
            if (w.cr < 7 && w.cc < 7 && w.cch < 3)
                coefs[w.cr][w.cc][w.cch] = int'(signed'(w.cv));
            return;
        end
        if (w.fs)
        begin
            m_col = 0;
            m_row = 0;
        end
        colv[0] = {w.s2, w.s1, w.s0};
        for (int d = 1; d < 7; d++)
            colv[d] = lines[d - 1][m_col];
        for (int d = 5; d >= 1; d--)
            lines[d][m_col] = lines[d - 1][m_col];
        lines[0][m_col] = colv[0];
        for (int d = 0; d < 7; d++)
        begin
            for (int j = 0; j < 6; j++)
                win[d][j] = win[d][j + 1];
            win[d][6] = colv[d];
        end
        if (m_row + 1 >= m_kh && m_col + 1 >= m_kw)
        begin
            o.row = 12'(m_row + 1 - m_kh);
            o.col = 11'(m_col + 1 - m_kw);
            o.r0 = filter_ch(0);
            o.r1 = filter_ch(1);
            o.r2 = filter_ch(2);
            expected_pix.push_back(o);
        end
        eff = (m_width == 0) ? 1 : (m_width > 2048) ? 2048 : m_width;
        if (m_col + 1 >= eff)
        begin
            m_col = 0;
            if (m_row < 4095)
                m_row++;
        end
        else
            m_col++;
    endtask

    // driver
    always @(negedge clk)
    begin
        word_t w;
        logic  nv;
        if (!in_valid || in_took)
        begin
            nv = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending.size() > 0)
            begin
                w = pending.pop_front();
                nv = 1'b1;
                opcode <= w.op;
                frame_start <= w.fs;
                sample_ch0 <= w.s0;
                sample_ch1 <= w.s1;
                sample_ch2 <= w.s2;
                coef_row <= w.cr;
                coef_col <= w.cc;
                coef_channel <= w.cch;
                coef_value <= w.cv;
                if (--burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 60);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            in_valid <= nv;
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (++stall_cnt >= 50)
        begin
            stall_cnt = 0;
            stall_mode = $urandom_range(0, 2);
        end
        out_ready <= (stall_mode == 0) ? 1'b1 :
                     (stall_mode == 1) ? 1'($urandom_range(0, 1)) :
                     ($urandom_range(0, 7) == 0);
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        pix_out_t e;
        word_t    w;
        in_took <= in_valid && in_ready;
        if (rst_n)
        begin
            idle_cycles++;
            if (out_valid && out_ready)
            begin
                idle_cycles = 0;
                if (expected_pix.size() == 0)
                begin
                    $display("%0t: unexpected word row=%0d col=%0d", $time, out_row, out_col);
                    errors++;
                end
                else
                begin
                    e = expected_pix.pop_front();
                    if (e.row !== out_row)
                    begin
                        $display("%0t: out_row exp %0d got %0d", $time, e.row, out_row);
                        errors++;
                    end
                    if (e.col !== out_col)
                    begin
                        $display("%0t: out_col exp %0d got %0d", $time, e.col, out_col);
                        errors++;
                    end
                    if (e.r0 !== result_ch0)
                    begin
                        $display("%0t: result_ch0 exp %0d got %0d", $time, e.r0, result_ch0);
                        errors++;
                    end
                    if (e.r1 !== result_ch1)
                    begin
                        $display("%0t: result_ch1 exp %0d got %0d", $time, e.r1, result_ch1);
                        errors++;
                    end
                    if (e.r2 !== result_ch2)
                    begin
                        $display("%0t: result_ch2 exp %0d got %0d", $time, e.r2, result_ch2);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                idle_cycles = 0;
                w.op = opcode;
                w.fs = frame_start;
                w.s0 = sample_ch0;
                w.s1 = sample_ch1;
                w.s2 = sample_ch2;
                w.cr = coef_row;
                w.cc = coef_col;
                w.cch = coef_channel;
                w.cv = coef_value;
                convolve_word(w);
            end
            if (idle_cycles >= 5000)
            begin
                $display("%0t: watchdog expired", $time);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic push_pixel(input logic fs, input logic [7:0] a, b, c);
        word_t w;
        w = '{mcwc_pkg::OP_PIXEL, fs, a, b, c, 3'($urandom), 3'($urandom), 2'($urandom),
              16'($urandom)};
        pending.push_back(w);
        rand_words++;
    endtask

    task automatic push_coef(input logic [2:0] r, cl, input logic [1:0] ch,
                             input logic [15:0] v);
        word_t w;
        w = '{mcwc_pkg::OP_COEF, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              r, cl, ch, v};
        pending.push_back(w);
        rand_words++;
    endtask

    function automatic logic [7:0] rand_px();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic drain();
        do
            @(posedge clk);
        while (pending.size() != 0 || in_valid || expected_pix.size() != 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == mcwc_pkg::CFG_IMAGE_WIDTH)
            m_width = val;
        else if (idx == mcwc_pkg::CFG_KERNEL_HEIGHT && val[0])
            m_kh = val[2:0];
        else if (idx == mcwc_pkg::CFG_KERNEL_WIDTH && val[0])
            m_kw = val[2:0];
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic random_frame(input int rows, input int w);
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < w; c++)
            begin
                if ($urandom_range(0, 19) == 0)
                    push_coef(3'($urandom), 3'($urandom), 2'($urandom), 16'($urandom));
                push_pixel(r == 0 && c == 0, rand_px(), rand_px(), rand_px());
            end
    endtask

    initial
    begin
        int w, kh, kw, sc;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: coefficient extremes, bad addresses, clamping on a 4-wide frame
        write_reg(mcwc_pkg::CFG_IMAGE_WIDTH, 12'd4);
        write_reg(mcwc_pkg::CFG_KERNEL_HEIGHT, 12'd2);
        write_reg(mcwc_pkg::CFG_KERNEL_WIDTH, 12'd0);
        push_coef(3'd0, 3'd0, 2'd0, 16'h7FFF);
        push_coef(3'd0, 3'd0, 2'd1, 16'h8000);
        push_coef(3'd1, 3'd1, 2'd2, 16'h0100);
        push_coef(3'd7, 3'd0, 2'd0, 16'h1234);
        push_coef(3'd0, 3'd7, 2'd1, 16'h1234);
        push_coef(3'd0, 3'd0, 2'd3, 16'h1234);
        push_coef(3'd2, 3'd2, 2'd2, 16'hFF80);
        for (int i = 0; i < 16; i++)
            push_pixel(i == 0, (i % 2) ? 8'd255 : 8'd0, 8'd255, 8'(i * 17));
        drain();

        // width 0 acts as 1; 1x1 kernel
        write_reg(mcwc_pkg::CFG_IMAGE_WIDTH, 12'd0);
        write_reg(mcwc_pkg::CFG_KERNEL_HEIGHT, 12'd1);
        write_reg(mcwc_pkg::CFG_KERNEL_WIDTH, 12'd1);
        for (int i = 0; i < 6; i++)
            push_pixel(i == 0, rand_px(), rand_px(), rand_px());
        drain();

        // width shrinks inside a frame with a 1x1 kernel
        write_reg(mcwc_pkg::CFG_IMAGE_WIDTH, 12'd10);
        for (int i = 0; i < 25; i++)
            push_pixel(i == 0, rand_px(), rand_px(), rand_px());
        drain();
        write_reg(mcwc_pkg::CFG_IMAGE_WIDTH, 12'd3);
        for (int i = 0; i < 12; i++)
            push_pixel(1'b0, rand_px(), rand_px(), rand_px());
        drain();

        // row counter saturation on a 1-wide image with a 7-row kernel
        write_reg(mcwc_pkg::CFG_IMAGE_WIDTH, 12'd1);
        write_reg(mcwc_pkg::CFG_KERNEL_HEIGHT, 12'd7);
        for (int i = 0; i < 7; i++)
            push_coef(3'(i), 3'd0, 2'($urandom_range(0, 2)), 16'($urandom_range(0, 60)));
        for (int i = 0; i < 4105; i++)
            push_pixel(i == 0, rand_px(), rand_px(), rand_px());
        drain();

        // widest image: oversized width acts as the maximum
        write_reg(mcwc_pkg::CFG_IMAGE_WIDTH, 12'd4095);
        write_reg(mcwc_pkg::CFG_KERNEL_HEIGHT, 12'd1);
        write_reg(mcwc_pkg::CFG_KERNEL_WIDTH, 12'd7);
        for (int j = 0; j < 7; j++)
            push_coef(3'd0, 3'(j), 2'($urandom_range(0, 2)), 16'($urandom_range(0, 40)));
        for (int i = 0; i < 2060; i++)
            push_pixel(i == 0, rand_px(), rand_px(), rand_px());
        drain();

        rand_words = 0;
        while (rand_words < 1850)
        begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 12);
            kh = 2 * $urandom_range(0, 3) + 1;
            kw = 2 * $urandom_range(0, 3) + 1;
            if (kw > w && $urandom_range(0, 3) != 0)
                kw = 1;
            write_reg(mcwc_pkg::CFG_IMAGE_WIDTH, 12'(w));
            if ($urandom_range(0, 3) == 0)
                write_reg(mcwc_pkg::CFG_KERNEL_HEIGHT, 12'(2 * $urandom_range(0, 3)));
            write_reg(mcwc_pkg::CFG_KERNEL_HEIGHT, 12'(kh));
            write_reg(mcwc_pkg::CFG_KERNEL_WIDTH, 12'(kw));
            sc = ($urandom_range(0, 4) == 0) ? 32767 : 80;
            for (int i = 0; i < kh; i++)
                for (int j = 0; j < kw; j++)
                    for (int ch = 0; ch < 3; ch++)
                        push_coef(3'(i), 3'(j), 2'(ch), 16'($urandom_range(0, 2 * sc) - sc));
            if ($urandom_range(0, 3) == 0)
                random_frame(1, $urandom_range(1, w));
            random_frame(kh + $urandom_range(0, 2), w);
            drain();
        end

        drain();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
